// ----- design/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the beat phase scheduler: sequencer states,
// register indexes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package bps_pkg;

  // parameter defaults
  localparam int RING_DEPTH_DEF    = 256;
  localparam int ADJUST_PERIOD_DEF = 16;
  localparam int PULSE_FRAMES_DEF  = 3;

  // field widths
  localparam int IDX_W   = 8;
  localparam int IVL_W   = 8;
  localparam int Q16_W   = 16;
  localparam int DLY_W   = 8;
  localparam int FPM_W   = 24;
  localparam int CFG_A_W = 2;
  localparam int PCNT_W  = 2;

  // serial divider: 17-bit dividend over an 8-bit divisor
  localparam int DIV_W   = 17;
  localparam int DCNT_W  = 5;

  localparam logic [DLY_W-1:0] DELAY_RESET  = '0;
  localparam logic             ADJUST_RESET = 1'b0;
  localparam logic [FPM_W-1:0] FPM_RESET    = 24'd661500;

  // one whole beat in Q1.16, used as the reciprocal dividend
  localparam logic [DIV_W-1:0] PHASE_ONE = 17'h10000;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_DELAY  = 2'd0,
    CFG_ADJUST = 2'd1,
    CFG_FPM    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DIV_TEMPO,
    ST_DIV_STEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_we;
    logic ring_we;
    logic ring_re;
    logic div_load_tempo;
    logic div_load_step;
    logic div_step;
    logic finish;
  } ctrl_t;

endpackage

// ----- design/beat_phase_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// beat_phase_scheduler_top
// Per-frame tempo, beat phase, scheduled beat pulse and delayed readback of
// beat, probability and silence through one ring memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the ring memory to zero, one entry per cycle,
// so it takes no item until the whole ring is cleared; configuration writes
// are taken throughout. Each item then passes from acceptance to a loaded
// result through one memory write, one memory read that also loads the
// divider, two passes of a shared restoring divider (17 shift steps and a
// hand-over step each, the first for the tempo and the second for the phase
// step 1/latched interval), and a finish cycle that waits for as long as the
// previous result still sits unaccepted in the output register. An item is
// accepted only in the idle state, so the next item is not taken until the
// previous one has finished. The result register lets the next item be
// accepted while the previous result waits. Configuration should only be
// written while no item is in flight.
module beat_phase_scheduler_top #(
  parameter int RING_DEPTH    = bps_pkg::RING_DEPTH_DEF,
  parameter int ADJUST_PERIOD = bps_pkg::ADJUST_PERIOD_DEF,
  parameter int PULSE_FRAMES  = bps_pkg::PULSE_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,

  input  logic        in_tvalid,
  output logic        in_tready,
  // frame_index[7:0], top_interval[15:8], beat_probability[31:16],
  // silence_level[47:32]
  input  logic [47:0] in_tdata,
  // beat_flag[0]
  input  logic [0:0]  in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // tempo_bpm[15:0], beat_phase[31:16], delayed_probability[47:32],
  // delayed_silence[63:48]
  output logic [63:0] out_tdata,
  // phase_valid[0], beat_pulse[1], click[2], delayed_beat[3]
  output logic [3:0]  out_tuser
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int MW = 2 * bps_pkg::Q16_W + 1;
  localparam logic [AW:0]   DEPTH_C = (AW + 1)'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(RING_DEPTH - 1);
  localparam logic [bps_pkg::PCNT_W-1:0] PULSE_C = bps_pkg::PCNT_W'(PULSE_FRAMES);

  function automatic logic [255:0] period_table();
    logic [255:0] t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ((i % ADJUST_PERIOD) == 0);
    end
    return t;
  endfunction

  localparam logic [255:0] PERIOD_HIT = period_table();

  // reduce an 8-bit value modulo the ring depth (depth is at least 16)
  function automatic logic [AW-1:0] ring_mod(input logic [7:0] v);
    logic [15:0] r;
    logic [15:0] d;
    r = 16'(v);
    for (int k = 3; k >= 0; k--) begin
      d = 16'(RING_DEPTH) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[AW-1:0];
  endfunction

  // configuration
  logic [bps_pkg::DLY_W-1:0] delay_r;
  logic                      adjust_r;
  logic [bps_pkg::FPM_W-1:0] fpm_r;

  // sequencer
  bps_pkg::state_t state_r, state_nxt;
  bps_pkg::ctrl_t  ctrl;
  logic [AW-1:0]   clr_cnt_r;

  // captured item
  logic [bps_pkg::IDX_W-1:0] frame_r;
  logic                      beat_r;
  logic [bps_pkg::IVL_W-1:0] interval_r;
  logic [bps_pkg::Q16_W-1:0] prob_r;
  logic [bps_pkg::Q16_W-1:0] sil_r;

  // scheduler and phase state
  logic [AW-1:0]              origin_r;
  logic                       pend_valid_r;
  logic [bps_pkg::IVL_W-1:0]  latched_r;
  logic [bps_pkg::Q16_W-1:0]  acc_r;
  logic                       known_r;
  logic [bps_pkg::PCNT_W-1:0] pcnt_r;
  logic                       fire_r;
  logic                       click_r;
  logic [AW-1:0]              rd_addr_r;
  logic [bps_pkg::Q16_W-1:0]  tempo_r;

  // divider
  logic [bps_pkg::DIV_W-1:0]  div_q_r;
  logic [bps_pkg::IVL_W-1:0]  div_rem_r;
  logic [bps_pkg::IVL_W-1:0]  div_dvs_r;
  logic [bps_pkg::DCNT_W-1:0] div_cnt_r;

  // ring memory: {beat, probability, silence}
  logic [MW-1:0] ring_mem [RING_DEPTH];
  logic [MW-1:0] rd_data_r;

  // output register
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [3:0]  out_user_r;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= bps_pkg::DELAY_RESET;
      adjust_r <= bps_pkg::ADJUST_RESET;
      fpm_r    <= bps_pkg::FPM_RESET;
    end else if (cfg_we) begin
      case (bps_pkg::cfg_idx_t'(cfg_index))
        bps_pkg::CFG_DELAY:  delay_r  <= cfg_wdata[bps_pkg::DLY_W-1:0];
        bps_pkg::CFG_ADJUST: adjust_r <= cfg_wdata[0];
        bps_pkg::CFG_FPM:    fpm_r    <= cfg_wdata[bps_pkg::FPM_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bps_pkg::ST_CLEAR: begin
        if (clr_cnt_r == LAST_C) begin
          state_nxt = bps_pkg::ST_IDLE;
        end
      end
      bps_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = bps_pkg::ST_WRITE;
        end
      end
      bps_pkg::ST_WRITE: state_nxt = bps_pkg::ST_READ;
      bps_pkg::ST_READ:  state_nxt = bps_pkg::ST_DIV_TEMPO;
      bps_pkg::ST_DIV_TEMPO: begin
        if (div_cnt_r == '0) begin
          state_nxt = bps_pkg::ST_DIV_STEP;
        end
      end
      bps_pkg::ST_DIV_STEP: begin
        if (div_cnt_r == '0) begin
          state_nxt = bps_pkg::ST_FINISH;
        end
      end
      bps_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = bps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bps_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      bps_pkg::ST_CLEAR:  ctrl.clr_we = 1'b1;
      bps_pkg::ST_IDLE:   ctrl.accept = 1'b1;
      bps_pkg::ST_WRITE:  ctrl.ring_we = 1'b1;
      bps_pkg::ST_READ: begin
        ctrl.ring_re        = 1'b1;
        ctrl.div_load_tempo = 1'b1;
      end
      bps_pkg::ST_DIV_TEMPO: begin
        ctrl.div_step      = (div_cnt_r != '0);
        ctrl.div_load_step = (div_cnt_r == '0);
      end
      bps_pkg::ST_DIV_STEP: ctrl.div_step = (div_cnt_r != '0);
      bps_pkg::ST_FINISH:   ctrl.finish   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bps_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.clr_we) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  assign in_tready = ctrl.accept;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      frame_r    <= in_tdata[7:0];
      interval_r <= in_tdata[15:8];
      prob_r     <= in_tdata[31:16];
      sil_r      <= in_tdata[47:32];
      beat_r     <= in_tuser[0];
    end
  end

  // --------------------------------------------------------------------------
  // Ring memory
  // --------------------------------------------------------------------------
  logic [AW-1:0] idx_w;
  logic [AW-1:0] dly_w;

  assign idx_w = ring_mod(frame_r);
  assign dly_w = ring_mod(delay_r);

  always_ff @(posedge clk) begin
    if (ctrl.clr_we) begin
      ring_mem[clr_cnt_r] <= '0;
    end else if (ctrl.ring_we) begin
      ring_mem[idx_w] <= {beat_r, prob_r, sil_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ring_re) begin
      rd_data_r <= ring_mem[rd_addr_r];
    end
  end

  // --------------------------------------------------------------------------
  // Scheduling (write cycle)
  // --------------------------------------------------------------------------
  logic          sched_w;
  logic [AW-1:0] origin_w;
  logic          pend_w;
  logic [AW:0]   due_sum;
  logic [AW:0]   due_w;
  logic          fire_w;
  logic [AW:0]   rd_diff;
  logic [AW:0]   rd_w;

  always_comb begin
    sched_w  = adjust_r ? PERIOD_HIT[8'(idx_w)] : beat_r;
    origin_w = sched_w ? idx_w : origin_r;
    pend_w   = sched_w || pend_valid_r;
    due_sum  = {1'b0, origin_w} + {1'b0, dly_w};
    due_w    = (due_sum >= DEPTH_C) ? due_sum - DEPTH_C : due_sum;
    fire_w   = pend_w && (due_w[AW-1:0] == idx_w);
    rd_diff  = {1'b0, idx_w} - {1'b0, dly_w};
    rd_w     = rd_diff[AW] ? rd_diff + DEPTH_C : rd_diff;
  end

  // --------------------------------------------------------------------------
  // Shared restoring divider
  // --------------------------------------------------------------------------
  logic [bps_pkg::IVL_W:0]   rem_sh;
  logic                      div_ge;
  logic [bps_pkg::IVL_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {div_rem_r, div_q_r[bps_pkg::DIV_W-1]};
    div_ge  = (rem_sh >= {1'b0, div_dvs_r});
    rem_sub = rem_sh - {1'b0, div_dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (ctrl.div_load_tempo || ctrl.div_load_step) begin
      div_cnt_r <= bps_pkg::DCNT_W'(bps_pkg::DIV_W);
    end else if (ctrl.div_step) begin
      div_cnt_r <= div_cnt_r - bps_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_load_tempo) begin
      // fpm / (interval * 256) equals (fpm >> 8) / interval
      div_q_r   <= {1'b0, fpm_r[bps_pkg::FPM_W-1:8]};
      div_dvs_r <= interval_r;
      div_rem_r <= '0;
    end else if (ctrl.div_load_step) begin
      div_q_r   <= bps_pkg::PHASE_ONE;
      div_dvs_r <= latched_r;
      div_rem_r <= '0;
    end else if (ctrl.div_step) begin
      div_q_r   <= {div_q_r[bps_pkg::DIV_W-2:0], div_ge};
      div_rem_r <= div_ge ? rem_sub[bps_pkg::IVL_W-1:0] : rem_sh[bps_pkg::IVL_W-1:0];
    end
  end

  // quotient never exceeds 16 bits, so no saturation is needed
  always_ff @(posedge clk) begin
    if (ctrl.div_load_step) begin
      tempo_r <= (interval_r == '0) ? '0 : div_q_r[bps_pkg::Q16_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Phase and pulse update (finish cycle)
  // --------------------------------------------------------------------------
  logic [bps_pkg::Q16_W+1:0]  phase_sum;
  logic                       wrapped;
  logic [bps_pkg::Q16_W-1:0]  acc_nxt;
  logic                       known_nxt;
  logic [bps_pkg::PCNT_W-1:0] pcnt_load;
  logic                       pulse_w;
  logic [bps_pkg::PCNT_W-1:0] pcnt_nxt;

  always_comb begin
    phase_sum = {2'b00, acc_r} + {1'b0, div_q_r};
    wrapped   = (phase_sum[bps_pkg::Q16_W+1:bps_pkg::Q16_W] != 2'b00);
    acc_nxt   = acc_r;
    known_nxt = known_r;
    if (fire_r) begin
      acc_nxt   = '0;
      known_nxt = 1'b1;
    end else if (latched_r == '0) begin
      acc_nxt   = '0;
      known_nxt = 1'b0;
    end else if (known_r) begin
      acc_nxt = wrapped ? '0 : phase_sum[bps_pkg::Q16_W-1:0];
    end else begin
      // climbing back from minus one: keep the excess once it passes one
      acc_nxt   = phase_sum[bps_pkg::Q16_W-1:0];
      known_nxt = wrapped;
    end
    pcnt_load = fire_r ? PULSE_C : pcnt_r;
    pulse_w   = (pcnt_load != '0);
    pcnt_nxt  = pulse_w ? pcnt_load - bps_pkg::PCNT_W'(1) : pcnt_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r     <= '0;
      pend_valid_r <= 1'b0;
      latched_r    <= '0;
      acc_r        <= '0;
      known_r      <= 1'b0;
      pcnt_r       <= '0;
      fire_r       <= 1'b0;
      click_r      <= 1'b0;
    end else begin
      if (ctrl.ring_we) begin
        origin_r     <= origin_w;
        pend_valid_r <= pend_w && !fire_w;
        fire_r       <= fire_w;
        click_r      <= fire_w && adjust_r;
        if (!adjust_r && beat_r) begin
          latched_r <= interval_r;
        end
      end
      if (ctrl.finish) begin
        acc_r   <= acc_nxt;
        known_r <= known_nxt;
        pcnt_r  <= pcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ring_we) begin
      rd_addr_r <= rd_w[AW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_data_r <= {rd_data_r[bps_pkg::Q16_W-1:0],
                     rd_data_r[2*bps_pkg::Q16_W-1:bps_pkg::Q16_W],
                     known_nxt ? acc_nxt : {bps_pkg::Q16_W{1'b0}},
                     tempo_r};
      out_user_r <= {rd_data_r[MW-1], click_r, pulse_w, known_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for beat_phase_scheduler_top. A behavioural model of
// tempo, beat phase, beat scheduling and the delayed ring readback predicts
// one report per frame. The monitor compares every report field by field
// while the frame sender pauses between bursts and the report sink stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [bps_pkg::Q16_W-1:0] tempo;
    logic [bps_pkg::Q16_W-1:0] phase;
    logic                      phase_valid;
    logic                      pulse;
    logic                      click;
    logic                      dly_beat;
    logic [bps_pkg::Q16_W-1:0] dly_prob;
    logic [bps_pkg::Q16_W-1:0] dly_sil;
  } frame_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  bps_pkg::cfg_idx_t cfg_index = bps_pkg::CFG_DELAY;
  logic [23:0]       cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [47:0]       in_tdata = '0;
  logic [0:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;
  logic [3:0]        out_tuser;

  beat_phase_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // model state
  logic                      beat_mem [bps_pkg::RING_DEPTH_DEF];
  logic [bps_pkg::Q16_W-1:0] prob_mem [bps_pkg::RING_DEPTH_DEF];
  logic [bps_pkg::Q16_W-1:0] sil_mem  [bps_pkg::RING_DEPTH_DEF];
  logic [bps_pkg::IDX_W-1:0] pend_origin;
  logic                      pend_valid;
  logic [bps_pkg::IVL_W-1:0] held_interval;
  int unsigned               phase_acc;
  logic                      phase_locked;
  int unsigned               pulse_left;
  logic [bps_pkg::DLY_W-1:0] cur_delay;
  logic                      cur_adjust;
  logic [bps_pkg::FPM_W-1:0] cur_fpm;

  frame_report_t reports_due[$];
  int unsigned   mismatches = 0;
  int unsigned   reports_seen = 0;
  int unsigned   burst_left = 0;
  int unsigned   sink_cycle = 0;

  initial begin
    for (int i = 0; i < bps_pkg::RING_DEPTH_DEF; i++) begin
      beat_mem[i] = 1'b0;
      prob_mem[i] = '0;
      sil_mem[i]  = '0;
    end
    pend_origin   = '0;
    pend_valid    = 1'b0;
    held_interval = '0;
    phase_acc     = 0;
    phase_locked  = 1'b0;
    pulse_left    = 0;
    cur_delay     = bps_pkg::DELAY_RESET;
    cur_adjust    = bps_pkg::ADJUST_RESET;
    cur_fpm       = bps_pkg::FPM_RESET;
  end

  function automatic frame_report_t predict_frame(
    input logic [bps_pkg::IDX_W-1:0] idx,
    input logic                      beat,
    input logic [bps_pkg::IVL_W-1:0] ivl,
    input logic [bps_pkg::Q16_W-1:0] prob,
    input logic [bps_pkg::Q16_W-1:0] sil);
    frame_report_t             rep;
    logic [bps_pkg::IDX_W-1:0] fire_at;
    logic [bps_pkg::IDX_W-1:0] rd;
    logic                      fire;
    int unsigned               sum;
    int unsigned               q;
    beat_mem[idx] = beat;
    prob_mem[idx] = prob;
    sil_mem[idx]  = sil;

    if (!cur_adjust) begin
      if (beat) begin
        pend_origin   = idx;
        pend_valid    = 1'b1;
        held_interval = ivl;
      end
    end else if (int'(idx) % bps_pkg::ADJUST_PERIOD_DEF == 0) begin
      pend_origin = idx;
      pend_valid  = 1'b1;
    end

    fire_at = pend_origin + cur_delay;
    fire = pend_valid && (fire_at == idx);
    rep.click = fire && cur_adjust;

    if (fire) begin
      pend_valid   = 1'b0;
      phase_acc    = 0;
      phase_locked = 1'b1;
    end else if (held_interval != 0) begin
      sum = phase_acc + 32'd65536 / int'(held_interval);
      if (phase_locked) begin
        phase_acc = (sum >= 32'd65536) ? 0 : sum;
      end else if (sum >= 32'd65536) begin
        phase_locked = 1'b1;
        phase_acc = sum - 32'd65536;
      end else begin
        phase_acc = sum;
      end
    end else begin
      phase_locked = 1'b0;
      phase_acc    = 0;
    end

    if (fire) pulse_left = bps_pkg::PULSE_FRAMES_DEF;
    rep.pulse = (pulse_left > 0);
    if (pulse_left > 0) pulse_left--;

    if (ivl == 0) begin
      rep.tempo = '0;
    end else begin
      q = int'(cur_fpm) / (int'(ivl) * 256);
      rep.tempo = (q > 65535) ? 16'hFFFF : q[15:0];
    end

    rep.phase       = phase_locked ? phase_acc[15:0] : '0;
    rep.phase_valid = phase_locked;
    rd = idx - cur_delay;
    rep.dly_beat = beat_mem[rd];
    rep.dly_prob = prob_mem[rd];
    rep.dly_sil  = sil_mem[rd];
    return rep;
  endfunction

  // bursts of random length with random gaps; valid stays high inside a burst
  task automatic send_frame(input logic [bps_pkg::IDX_W-1:0] idx, input logic beat,
                            input logic [bps_pkg::IVL_W-1:0] ivl,
                            input logic [bps_pkg::Q16_W-1:0] prob,
                            input logic [bps_pkg::Q16_W-1:0] sil);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
        burst_left = $urandom_range(30, 80);
      end else begin
        gap = $urandom_range(1, 20);
        burst_left = $urandom_range(1, 12);
      end
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {sil, prob, ivl, idx};
    in_tuser  <= beat;
    do @(posedge clk); while (!in_tready);
    reports_due.push_back(predict_frame(idx, beat, ivl, prob, sil));
  endtask

  task automatic drain_reports();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // hold write enable across the three registers, one per edge
  task automatic set_registers(input logic [bps_pkg::DLY_W-1:0] dly, input logic adj,
                               input logic [bps_pkg::FPM_W-1:0] fpm);
    drain_reports();
    cfg_we    <= 1'b1;
    cfg_index <= bps_pkg::CFG_DELAY;
    cfg_wdata <= {16'd0, dly};
    @(posedge clk);
    cfg_index <= bps_pkg::CFG_ADJUST;
    cfg_wdata <= {23'd0, adj};
    @(posedge clk);
    cfg_index <= bps_pkg::CFG_FPM;
    cfg_wdata <= fpm;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_delay  = dly;
    cur_adjust = adj;
    cur_fpm    = fpm;
  endtask

  task automatic test_reset_values();
    send_frame(8'd0, 1'b0, 8'd0, 16'h0000, 16'h0000);
    send_frame(8'd1, 1'b1, 8'd255, 16'hFFFF, 16'hFFFF);
    send_frame(8'd2, 1'b0, 8'd1, 16'h0000, 16'h0000);
    send_frame(8'd255, 1'b0, 8'd0, 16'h1234, 16'h8000);
  endtask

  task automatic test_field_extremes();
    set_registers(8'd0, 1'b0, 24'hFFFFFF);
    send_frame(8'd0, 1'b1, 8'd1, 16'hFFFF, 16'h0000);
    send_frame(8'd1, 1'b0, 8'd1, 16'h0000, 16'hFFFF);
    send_frame(8'd2, 1'b1, 8'd0, 16'h5555, 16'hAAAA);
    send_frame(8'd3, 1'b0, 8'd0, 16'hAAAA, 16'h5555);
    // zero frame rate gives zero tempo
    set_registers(8'd0, 1'b0, 24'd0);
    send_frame(8'd4, 1'b0, 8'd200, 16'h0001, 16'h0100);
  endtask

  task automatic test_reschedule();
    set_registers(8'd3, 1'b0, bps_pkg::FPM_RESET);
    send_frame(8'd10, 1'b1, 8'd4, 16'h1000, 16'h0200);
    // replaces the pending beat and relatches the interval
    send_frame(8'd11, 1'b1, 8'd2, 16'h2000, 16'h0300);
    for (int i = 12; i < 18; i++)
      send_frame(i[7:0], 1'b0, 8'd2, 16'(i * 1000), 16'(i * 77));
  endtask

  task automatic test_delay_wrap();
    set_registers(8'd250, 1'b0, 24'd1);
    send_frame(8'd5, 1'b1, 8'd7, 16'hBEEF, 16'h0F0F);
    send_frame(8'd255, 1'b0, 8'd7, 16'h0001, 16'hF0F0);
  endtask

  task automatic test_adjust_click();
    set_registers(8'd0, 1'b1, bps_pkg::FPM_RESET);
    send_frame(8'd16, 1'b0, 8'd20, 16'h4000, 16'h0400);
    send_frame(8'd17, 1'b1, 8'd20, 16'h4001, 16'h0401);
    send_frame(8'd32, 1'b1, 8'd9, 16'h4002, 16'h0402);
    set_registers(8'd245, 1'b1, bps_pkg::FPM_RESET);
    send_frame(8'd16, 1'b0, 8'd9, 16'h7000, 16'h0700);
    send_frame(8'd5, 1'b0, 8'd9, 16'h7001, 16'h0701);
  endtask

  function automatic logic [bps_pkg::Q16_W-1:0] pick_level();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // beat trains of a random period over mostly consecutive frame indexes
  task automatic test_random_frames(input int phases, input int frames_per_phase);
    logic [bps_pkg::IDX_W-1:0] idx;
    logic                      beat;
    logic [bps_pkg::IVL_W-1:0] ivl;
    logic [bps_pkg::DLY_W-1:0] dly;
    logic [bps_pkg::FPM_W-1:0] fpm;
    int unsigned               period;
    int unsigned               count;
    int unsigned               r;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0: set_registers(8'd0, 1'b0, bps_pkg::FPM_RESET);
        1: set_registers(8'd1, 1'b1, 24'hFFFFFF);
        2: set_registers(8'd245, 1'b0, 24'd1);
        3: set_registers(8'd255, 1'b1, 24'd0);
        default: begin
          dly = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
          case ($urandom_range(0, 4))
            0: fpm = 24'd1;
            1: fpm = 24'hFFFFFF;
            2: fpm = bps_pkg::FPM_RESET;
            default: fpm = 24'($urandom);
          endcase
          set_registers(dly, 1'($urandom_range(0, 1)), fpm);
        end
      endcase
      idx = 8'($urandom);
      period = $urandom_range(1, 48);
      count = 0;
      for (int i = 0; i < frames_per_phase; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4) idx = 8'($urandom);
        else idx = idx + 1'b1;
        beat = (count == 0);
        count = (count + 1) % period;
        if (r >= 4 && r < 9) beat = ~beat;
        case ($urandom_range(0, 19))
          0: ivl = '0;
          1, 2: ivl = 8'($urandom);
          default: ivl = 8'(period);
        endcase
        send_frame(idx, beat, ivl, pick_level(), pick_level());
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report %0d: %s expected %0d, got %0d", reports_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report %0d arrived with nothing expected: tdata %h tuser %h",
                   reports_seen, out_tdata, out_tuser);
      end else begin
        want = reports_due.pop_front();
        check_field("tempo_bpm", want.tempo, out_tdata[15:0]);
        check_field("beat_phase", want.phase, out_tdata[31:16]);
        check_field("phase_valid", want.phase_valid, out_tuser[0]);
        check_field("beat_pulse", want.pulse, out_tuser[1]);
        check_field("click", want.click, out_tuser[2]);
        check_field("delayed_beat", want.dly_beat, out_tuser[3]);
        check_field("delayed_probability", want.dly_prob, out_tdata[47:32]);
        check_field("delayed_silence", want.dly_sil, out_tdata[63:48]);
      end
      reports_seen++;
    end
  end

  // sink stall pattern: free running, mostly ready, sparse, coin toss
  always @(posedge clk) begin
    sink_cycle++;
    case ((sink_cycle / 512) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ((sink_cycle % 7) < 2);
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("beat_phase_scheduler_top regression: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_field_extremes();
    test_reschedule();
    test_delay_wrap();
    test_adjust_click();
    test_random_frames(10, 175);
    drain_reports();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("beat_phase_scheduler_top regression: pass");
    end else begin
      $display("beat_phase_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
